// ----- rtl/buddy_block_allocator_defines.svh -----
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BBA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");
// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/bba_pkg.sv -----
// shared types and constants of the buddy block allocator
package bba_pkg;

   // default sizing
   localparam int HEAP_LOG2_DEF      = 16;
   localparam int MIN_BLOCK_LOG2_DEF = 5;
   localparam int LEVELS_DEF         = 11;
   localparam int HEADER_BYTES_DEF   = 24;

   // fixed field and word widths
   localparam int LVW       = 4;
   localparam int WORD_BITS = 32;
   localparam int WORD_LOG2 = 5;
   localparam int CHUNK_W   = 17;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NO_FREE   = 2'd1;
   localparam status_type ST_TOO_LARGE = 2'd2;
   localparam status_type ST_BAD_FREE  = 2'd3;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] request_bytes;
      logic [15:0] payload_offset_in;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] payload_offset;
      logic [3:0]  block_level;
   } rsp_type;

   // result of the free-bit search over one word
   typedef struct packed {
      logic                 hit;
      logic [WORD_LOG2-1:0] pos;
   } pick_type;

endpackage

// ----- rtl/buddy_block_allocator.sv -----
// buddy block allocator: top level with sequencer, level counters and mark stores
//
// req channel carries one command per beat: allocate request_bytes, or free the
// payload at payload_offset_in. rsp channel returns one beat per command with
// status, payload_offset and block_level. Both use valid/stall handshakes.
// One command is worked at a time; req_stall is high while it is in flight.
// The free marks sit in a 32-bit-word memory walked by one search unit.
// Allocate: the decode checks the size and the find step picks a level; the
// level's mark words are scanned in turn (up to 64 at level 0), each split
// reads and writes a mark, the slot's level and granted mark are written and
// the result is loaded. Free: the decode and a granted-mark read check it,
// each merge step reads and clears a buddy mark, the final mark is set and
// the result is loaded. A rejected command goes to the output from the
// decode, the find step (no block free) or the granted-mark check (slot not
// granted). After reset a clearing pass over the 128 mark words writes the
// initial free marks and clears the granted marks; req_stall stays high.
// A result waits in an output register while rsp_stall is high; the next
// command is still accepted and finishes once that register is free.
`include "buddy_block_allocator_defines.svh"
module buddy_block_allocator #(
   parameter int HEAP_LOG2      = bba_pkg::HEAP_LOG2_DEF,
   parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF,
   parameter int LEVELS         = bba_pkg::LEVELS_DEF,
   parameter int HEADER_BYTES   = bba_pkg::HEADER_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bba_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bba_pkg::rsp_type rsp_payload
);
   import bba_pkg::*;

   localparam int TOP_LOG2 = MIN_BLOCK_LOG2 + LEVELS - 1;
   localparam int SW       = HEAP_LOG2 - MIN_BLOCK_LOG2;
   localparam int NUM_MIN  = 1 << SW;
   localparam int IW       = SW + 2;
   localparam int MWORDS   = (2 * NUM_MIN + WORD_BITS - 1) / WORD_BITS;
   localparam int MAW      = (MWORDS > 1) ? $clog2(MWORDS) : 1;
   localparam int VWORDS   = (NUM_MIN + WORD_BITS - 1) / WORD_BITS;
   localparam int VAW      = (VWORDS > 1) ? $clog2(VWORDS) : 1;
   localparam int CNW      = SW + 1;
   localparam int AW       = HEAP_LOG2;
   localparam int LEVW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int TOP_CNT  = NUM_MIN >> (LEVELS - 1);
   localparam int TOP_BASE = 2 * NUM_MIN - ((2 * NUM_MIN) >> (LEVELS - 1));

   typedef enum logic [14:0] {
      S_CLEAR    = 15'b000000000000001,
      S_IDLE     = 15'b000000000000010,
      S_FIND     = 15'b000000000000100,
      S_SCAN     = 15'b000000000001000,
      S_SPLIT_RD = 15'b000000000010000,
      S_SPLIT_WR = 15'b000000000100000,
      S_VAL_RD   = 15'b000000001000000,
      S_VAL_WR   = 15'b000000010000000,
      S_F_RD     = 15'b000000100000000,
      S_F_CHK    = 15'b000001000000000,
      S_MRG_RD   = 15'b000010000000000,
      S_MRG_WR   = 15'b000100000000000,
      S_SET_RD   = 15'b001000000000000,
      S_SET_WR   = 15'b010000000000000,
      S_OUT      = 15'b100000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [LVW-1:0]      lvl_ff, lvl_in;
   logic [LVW-1:0]      want_ff, want_in;
   logic [AW-1:0]       start_ff, start_in;
   logic [MAW-1:0]      scan_w_ff, scan_w_in;
   logic [MAW-1:0]      clr_ff, clr_in;
   logic [CNW-1:0]      cnt_ff [LEVELS];
   logic [CNW-1:0]      cnt_in [LEVELS];
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic                 mk_we;
   logic [MAW-1:0]       mk_waddr, mk_raddr;
   logic [WORD_BITS-1:0] mk_wdata, mk_rdata;
   logic                 v_we;
   logic [VAW-1:0]       v_waddr, v_word;
   logic [WORD_BITS-1:0] v_wdata, v_rdata, v_bit;
   logic                 lv_we;
   logic [SW-1:0]        slot;
   logic [LVW-1:0]       lv_rdata;

   // address arithmetic
   logic [IW-1:0]        base_sel, hi_sel, base_fl;
   logic [AW-1:0]        size_sel, tgt_addr, hit_start;
   logic [IW-1:0]        mk_idx;
   logic [MAW-1:0]       mk_word;
   logic [WORD_BITS-1:0] mk_bit, init_word;
   logic                 bit_set;
   logic [31:0]          hit_idx;
   pick_type             pick;
   logic [CNW-1:0]       cnt_sel;
   logic                 cnt_inc, cnt_dec;

   // command decode
   logic [CHUNK_W-1:0]   chunk;
   logic                 too_large;
   logic [LVW-1:0]       want;
   logic [LVW-1:0]       fl;
   logic                 found;
   logic [15:0]          fstart;
   logic                 bad_free;
   logic [LVW-1:0]       lv_clamp;
   logic                 res_load;

   // mark, granted-slot and level stores
   bba_ram #(.W(WORD_BITS), .DEPTH(MWORDS), .AW(MAW)) u_marks (
      .clock(clock), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
      .raddr(mk_raddr), .rdata(mk_rdata)
   );

   bba_ram #(.W(WORD_BITS), .DEPTH(VWORDS), .AW(VAW)) u_valid (
      .clock(clock), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
      .raddr(v_word), .rdata(v_rdata)
   );

   bba_ram #(.W(LVW), .DEPTH(NUM_MIN), .AW(SW)) u_level (
      .clock(clock), .we(lv_we), .waddr(slot), .wdata(want_ff),
      .raddr(slot), .rdata(lv_rdata)
   );

   // free-bit search unit
   bba_pick #(.IW(IW), .MAW(MAW)) u_pick (
      .word(mk_rdata), .word_idx(scan_w_ff), .lo(base_sel), .hi(hi_sel), .pick(pick)
   );

   // level geometry for the current level
   always_comb begin
      base_sel = IW'(2 * NUM_MIN) - (IW'(2 * NUM_MIN) >> lvl_ff);
      hi_sel   = base_sel + (IW'(NUM_MIN) >> lvl_ff);
      size_sel = (AW'(1) << MIN_BLOCK_LOG2) << lvl_ff;
      base_fl  = IW'(2 * NUM_MIN) - (IW'(2 * NUM_MIN) >> fl);
      cnt_sel  = cnt_ff[LEVW'(lvl_ff)];
   end

   // target block of the current mark update
   always_comb begin
      case (state_ff)
         S_SPLIT_RD, S_SPLIT_WR: tgt_addr = start_ff + size_sel;
         S_MRG_RD, S_MRG_WR:     tgt_addr = start_ff ^ size_sel;
         default:                tgt_addr = start_ff;
      endcase
      mk_idx  = base_sel + IW'((start_ff >> 0) == tgt_addr ?
                 (tgt_addr >> MIN_BLOCK_LOG2) >> lvl_ff :
                 (tgt_addr >> MIN_BLOCK_LOG2) >> lvl_ff);
      mk_word = MAW'(mk_idx >> WORD_LOG2);
      mk_bit  = WORD_BITS'(1) << WORD_LOG2'(mk_idx);
      bit_set = |(mk_rdata & mk_bit);
      hit_idx = (32'(scan_w_ff) << WORD_LOG2) + 32'(pick.pos);
      hit_start = (AW'(hit_idx - 32'(base_sel)) << MIN_BLOCK_LOG2) << lvl_ff;
   end

   // granted-slot addressing
   always_comb begin
      slot   = SW'(start_ff >> MIN_BLOCK_LOG2);
      v_word = VAW'((start_ff >> MIN_BLOCK_LOG2) >> WORD_LOG2);
      v_bit  = WORD_BITS'(1) << WORD_LOG2'(start_ff >> MIN_BLOCK_LOG2);
   end

   // reset pattern of one mark word
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         init_word[b] = (((32'(clr_ff) << WORD_LOG2) + 32'(b)) >= 32'(TOP_BASE))
            && (((32'(clr_ff) << WORD_LOG2) + 32'(b)) < 32'(TOP_BASE + TOP_CNT));
      end
   end

   // allocate decode: size check and wanted level
   always_comb begin
      chunk     = CHUNK_W'(req_payload.request_bytes) + CHUNK_W'(HEADER_BYTES);
      too_large = 32'(chunk) > (32'(1) << TOP_LOG2);
      want      = LVW'(LEVELS - 1);
      for (int l = LEVELS - 2; l >= 0; l--) begin
         if ((32'(1) << (MIN_BLOCK_LOG2 + l)) >= 32'(chunk)) begin
            want = LVW'(l);
         end
      end
   end

   // smallest non-empty level at or above the wanted one
   always_comb begin
      found = 1'b0;
      fl    = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (LVW'(l) >= want_ff && cnt_ff[l] != '0) begin
            found = 1'b1;
            fl    = LVW'(l);
         end
      end
   end

   // free decode
   always_comb begin
      fstart   = req_payload.payload_offset_in - 16'(HEADER_BYTES);
      bad_free = (req_payload.payload_offset_in < 16'(HEADER_BYTES))
         || ((fstart & 16'((1 << MIN_BLOCK_LOG2) - 1)) != 16'd0)
         || ((32'(fstart) >> HEAP_LOG2) != 32'd0);
      lv_clamp = (lv_rdata > LVW'(LEVELS - 1)) ? LVW'(LEVELS - 1) : lv_rdata;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      want_in   = want_ff;
      start_in  = start_ff;
      scan_w_in = scan_w_ff;
      clr_in    = clr_ff;
      res_in    = res_ff;
      mk_we     = 1'b0;
      mk_waddr  = mk_word;
      mk_wdata  = mk_rdata | mk_bit;
      mk_raddr  = mk_word;
      v_we      = 1'b0;
      v_waddr   = v_word;
      v_wdata   = v_rdata | v_bit;
      lv_we     = 1'b0;
      cnt_inc   = 1'b0;
      cnt_dec   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mk_we    = 1'b1;
            mk_waddr = clr_ff;
            mk_wdata = init_word;
            v_we     = 32'(clr_ff) < 32'(VWORDS);
            v_waddr  = VAW'(clr_ff);
            v_wdata  = '0;
            clr_in   = clr_ff + MAW'(1);
            if (clr_ff == MAW'(MWORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_payload.command == CMD_ALLOC) begin
                  if (too_large) begin
                     res_in.status = ST_TOO_LARGE;
                     state_in      = S_OUT;
                  end else begin
                     want_in  = want;
                     state_in = S_FIND;
                  end
               end else begin
                  start_in = AW'(fstart);
                  if (bad_free) begin
                     res_in.status = ST_BAD_FREE;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_F_RD;
                  end
               end
            end
         end
         S_FIND: begin
            mk_raddr  = MAW'(base_fl >> WORD_LOG2);
            scan_w_in = MAW'(base_fl >> WORD_LOG2);
            lvl_in    = fl;
            if (found) begin
               state_in = S_SCAN;
            end else begin
               res_in.status = ST_NO_FREE;
               state_in      = S_OUT;
            end
         end
         S_SCAN: begin
            mk_raddr = scan_w_ff + MAW'(1);
            if (pick.hit) begin
               mk_we    = 1'b1;
               mk_waddr = scan_w_ff;
               mk_wdata = mk_rdata & ~(WORD_BITS'(1) << pick.pos);
               cnt_dec  = 1'b1;
               start_in = hit_start;
               if (lvl_ff > want_ff) begin
                  lvl_in   = lvl_ff - LVW'(1);
                  state_in = S_SPLIT_RD;
               end else begin
                  state_in = S_VAL_RD;
               end
            end else begin
               scan_w_in = scan_w_ff + MAW'(1);
            end
         end
         S_SPLIT_RD: begin
            state_in = S_SPLIT_WR;
         end
         S_SPLIT_WR: begin
            mk_we   = 1'b1;
            cnt_inc = 1'b1;
            if (lvl_ff > want_ff) begin
               lvl_in   = lvl_ff - LVW'(1);
               state_in = S_SPLIT_RD;
            end else begin
               state_in = S_VAL_RD;
            end
         end
         S_VAL_RD: begin
            lv_we    = 1'b1;
            state_in = S_VAL_WR;
         end
         S_VAL_WR: begin
            v_we                  = 1'b1;
            res_in.status         = ST_OK;
            res_in.payload_offset = 16'(32'(start_ff) + 32'(HEADER_BYTES));
            res_in.block_level    = want_ff;
            state_in              = S_OUT;
         end
         S_F_RD: begin
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (|(v_rdata & v_bit)) begin
               v_we    = 1'b1;
               v_wdata = v_rdata & ~v_bit;
               want_in = lv_clamp;
               lvl_in  = lv_clamp;
               if (lv_clamp < LVW'(LEVELS - 1)) begin
                  state_in = S_MRG_RD;
               end else begin
                  state_in = S_SET_RD;
               end
            end else begin
               res_in.status = ST_BAD_FREE;
               state_in      = S_OUT;
            end
         end
         S_MRG_RD: begin
            state_in = S_MRG_WR;
         end
         S_MRG_WR: begin
            if (bit_set) begin
               mk_we    = 1'b1;
               mk_wdata = mk_rdata & ~mk_bit;
               cnt_dec  = 1'b1;
               start_in = start_ff & ~size_sel;
               lvl_in   = lvl_ff + LVW'(1);
               if (32'(lvl_ff) + 32'd1 < 32'(LEVELS - 1)) begin
                  state_in = S_MRG_RD;
               end else begin
                  state_in = S_SET_RD;
               end
            end else begin
               state_in = S_SET_RD;
            end
         end
         S_SET_RD: begin
            state_in = S_SET_WR;
         end
         S_SET_WR: begin
            mk_we                 = 1'b1;
            cnt_inc               = 1'b1;
            res_in.status         = ST_OK;
            res_in.payload_offset = '0;
            res_in.block_level    = want_ff;
            state_in              = S_OUT;
         end
         S_OUT: begin
            if (res_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // free block counts per level
   always_comb begin
      cnt_in = cnt_ff;
      if (cnt_inc) begin
         cnt_in[LEVW'(lvl_ff)] = cnt_sel + CNW'(1);
      end else if (cnt_dec) begin
         cnt_in[LEVW'(lvl_ff)] = cnt_sel - CNW'(1);
      end
   end

   // output register
   always_comb begin
      res_load     = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LEVELS; l++) begin
            cnt_ff[l] <= (l == LEVELS - 1) ? CNW'(TOP_CNT) : '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      want_ff   <= want_in;
      start_ff  <= start_in;
      scan_w_ff <= scan_w_in;
      res_ff    <= res_in;
      if (res_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `BBA_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   `BBA_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && rsp_payload.status != ST_OK, rsp_payload.payload_offset == 16'd0 && rsp_payload.block_level == 4'd0)
   `BBA_ASSERT_SAME(a_hit_nonempty, clock, reset, state_ff == S_SCAN && pick.hit, cnt_sel != '0)
   `BBA_ASSERT_SAME(a_clear_stalls, clock, reset, state_ff == S_CLEAR, req_stall)
endmodule

// ----- rtl/bba_ram.sv -----
// simple dual-port memory with registered read
module bba_ram #(
   parameter int W     = 32,
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);
   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/bba_pick.sv -----
// first free mark of one word inside a level's index range
module bba_pick #(
   parameter int IW  = 13,
   parameter int MAW = 7
) (
   input  logic [bba_pkg::WORD_BITS-1:0] word,
   input  logic [MAW-1:0]                word_idx,
   input  logic [IW-1:0]                 lo,
   input  logic [IW-1:0]                 hi,
   output bba_pkg::pick_type             pick
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] cand;

   // range mask on the word
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         cand[b] = word[b]
            && (((32'(word_idx) << WORD_LOG2) + 32'(b)) >= 32'(lo))
            && (((32'(word_idx) << WORD_LOG2) + 32'(b)) < 32'(hi));
      end
   end

   // lowest set bit
   always_comb begin
      pick.hit = |cand;
      pick.pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            pick.pos = WORD_LOG2'(b);
         end
      end
   end
endmodule
